// ===== sv/sws_pkg.sv =====
// ---------------------------------------------------------------------------
// sws_pkg: shared types and constants of the sorting block
// Field widths, the request item that passes from intake to sort engine,
// and the default capacity of the element store.
// ---------------------------------------------------------------------------
`default_nettype none

package sws_pkg;

   // fixed field widths
   localparam int VALUE_W      = 8;
   localparam int POS_W        = 6;
   localparam int MEAN_W       = 16;
   localparam int FRAC_W       = 8;
   localparam int REQ_DATA_W   = 8;
   localparam int RSP_DATA_W   = 56;
   localparam int RSP_PAD_W    = RSP_DATA_W - (4 * VALUE_W + POS_W + MEAN_W);

   // default store capacity
   localparam int MAX_ELEMENTS_DEFAULT = 32;

   // intake queue
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = 1;
   localparam int QFILL_W      = 2;

   // one request after intake: value, end-of-set mark, over-capacity mark
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
      logic               drop;
   } sws_item_type;

endpackage

`default_nettype wire

// ===== sv/sort_with_order_statistics.sv =====
// ---------------------------------------------------------------------------
// sort_with_order_statistics: stream sorter with min, max, median and mean
// Requests on req_* carry one 8-bit value each; req_tlast closes a set.
// Up to MAX_ELEMENTS values are kept, later ones are dropped and flagged.
// After the closing request the set is sorted ascending and sent on rsp_*,
// one response per stored value, smallest first, rsp_tlast on the final one.
// Every response repeats the set's minimum, maximum, median, 8.8 mean and
// the overflow flag (rsp_tuser).
// Flow: requests enter a two-entry queue at one per cycle while it is not
// full; the sort engine stores one per cycle while it loads a set. Sorting
// repeats bubble passes, one compare per cycle, until a pass swaps nothing;
// the serial mean divider then yields one quotient bit per dividend bit.
// Responses leave at one per cycle while rsp_tready is high; a stalled rsp
// holds its response while the queue keeps taking requests until it is full.
// Reset (synchronous, active high) empties the queue and the set and
// drops any response in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module sort_with_order_statistics #(
   parameter int MAX_ELEMENTS = sws_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [sws_pkg::REQ_DATA_W-1:0] req_tdata,  // [7:0] value
   input  wire logic                           req_tlast,  // last of set
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [7:0] sorted_value, [13:8] position, [21:14] minimum, [29:22] maximum,
   // [37:30] median, [53:38] mean_fixed, [55:54] zero
   output logic [sws_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tlast,  // last_res
   output logic                                rsp_tuser   // [0] overflow
);

   logic                  item_valid;
   logic                  item_ready;
   sws_pkg::sws_item_type item;

   sws_front #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   sws_back #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // median lies between minimum and maximum
   a_median_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[21:14] <= rsp_tdata[37:30]) &&
                     (rsp_tdata[37:30] <= rsp_tdata[29:22]))
      else $error("median outside min/max");

   // every sorted value lies between minimum and maximum
   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[21:14] <= rsp_tdata[7:0]) &&
                     (rsp_tdata[7:0] <= rsp_tdata[29:22]))
      else $error("sorted value outside min/max");

   // the set ends after its final response
   a_set_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid)
      else $error("response after end of set");

   // no request is taken from the queue while responses go out
   a_no_load_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !item_ready)
      else $error("queue drained during emission");

endmodule

`default_nettype wire

// ===== sv/sws_front.sv =====
// ---------------------------------------------------------------------------
// sws_front: request intake
// Accepts requests, marks those beyond the store capacity for dropping and
// buffers them in a two-entry queue ahead of the sort engine.
// ---------------------------------------------------------------------------
`default_nettype none

module sws_front #(
   parameter int MAX_ELEMENTS = sws_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [sws_pkg::REQ_DATA_W-1:0] req_tdata,   // [7:0] value
   input  wire logic                           req_tlast,   // end of set
   output logic                                item_valid,
   input  wire logic                           item_ready,
   output sws_pkg::sws_item_type               item
);

   localparam int CW = $clog2(MAX_ELEMENTS + 1);

   sws_pkg::sws_item_type             q_ff [sws_pkg::QUEUE_DEPTH];
   sws_pkg::sws_item_type             q_in;
   logic [sws_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [sws_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [sws_pkg::QFILL_W-1:0]       fill_ff, fill_in;
   logic [CW-1:0]                     cnt_ff, cnt_in;
   logic                              push, pop, full;

   // classify and queue
   always_comb begin
      full       = (fill_ff == sws_pkg::QFILL_W'(sws_pkg::QUEUE_DEPTH));
      req_tready = !full;
      item_valid = (fill_ff != '0);
      item       = q_ff[rd_ptr_ff];
      push       = req_tvalid && req_tready;
      pop        = item_valid && item_ready;

      q_in.value = req_tdata[sws_pkg::VALUE_W-1:0];
      q_in.last  = req_tlast;
      q_in.drop  = (cnt_ff == CW'(MAX_ELEMENTS));

      cnt_in    = cnt_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;

      // count stored requests of the current set
      if (push) begin
         if (req_tlast) begin
            cnt_in = '0;
         end else if (!q_in.drop) begin
            cnt_in = cnt_ff + CW'(1);
         end
         wr_ptr_in = wr_ptr_ff + sws_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + sws_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + sws_pkg::QFILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - sws_pkg::QFILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         cnt_ff    <= cnt_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= q_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/sws_div.sv =====
// ---------------------------------------------------------------------------
// sws_div: serial restoring divider
// Produces one quotient bit per cycle; done pulses with the quotient ready.
// ---------------------------------------------------------------------------
`default_nettype none

module sws_div #(
   parameter int NUM_W = 21,
   parameter int DEN_W = 6
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic [NUM_W-1:0]      quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [DEN_W-1:0]   rem_ff, rem_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [DEN_W:0]     shifted, diff;
   logic               ge;

   // one shift-subtract step per cycle
   always_comb begin
      shifted = {rem_ff, num_ff[NUM_W-1]};
      diff    = shifted - {1'b0, den_ff};
      ge      = (shifted >= {1'b0, den_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], ge};
         rem_in = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = num_ff;

endmodule

`default_nettype wire

// ===== sv/sws_back.sv =====
// ---------------------------------------------------------------------------
// sws_back: sort engine and result emitter
// Stores a set in a shift line, bubble sorts it one compare per cycle,
// derives median and mean, then shifts the sorted set out as responses.
// ---------------------------------------------------------------------------
`default_nettype none

module sws_back #(
   parameter int MAX_ELEMENTS = sws_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           item_valid,
   output logic                                item_ready,
   input  wire sws_pkg::sws_item_type          item,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [sws_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                rsp_tuser
);

   localparam int VW    = sws_pkg::VALUE_W;
   localparam int CW    = $clog2(MAX_ELEMENTS + 1);
   localparam int IDX_W = $clog2(MAX_ELEMENTS);
   localparam int SUM_W = $clog2(MAX_ELEMENTS * 255 + 1);
   localparam int NUM_W = SUM_W + sws_pkg::FRAC_W;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SORT,
      ST_MEAN,
      ST_EMIT
   } state_type;

   state_type                  state_ff, state_in;
   logic [VW-1:0]              sr_ff [MAX_ELEMENTS];
   logic [VW-1:0]              sr_in [MAX_ELEMENTS];
   logic [CW-1:0]              count_ff, count_in;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic                       ovf_ff, ovf_in;
   logic [VW-1:0]              min_ff, min_in;
   logic [VW-1:0]              max_ff, max_in;
   logic [CW-1:0]              step_ff, step_in;
   logic                       moved_ff, moved_in;
   logic [CW-1:0]              emit_ff, emit_in;
   logic [VW-1:0]              lo_ff, lo_in;
   logic [VW-1:0]              hi_ff, hi_in;
   logic [VW-1:0]              med_ff, med_in;
   logic [sws_pkg::MEAN_W-1:0] mean_ff, mean_in;

   logic [VW-1:0]              head, nxt, out_v;
   logic [VW:0]                pair_sum;
   logic                       swap, last_step, final_rsp;
   logic [CW-1:0]              mid;
   logic [IDX_W-1:0]           tail_idx;
   logic                       div_start, div_done;
   logic [NUM_W-1:0]           div_quo;

   sws_div #(
      .NUM_W (NUM_W),
      .DEN_W (CW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   ({sum_ff, sws_pkg::FRAC_W'(0)}),
      .den   (count_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      head      = sr_ff[0];
      nxt       = sr_ff[1];
      swap      = (head > nxt);
      last_step = (step_ff == count_ff);
      out_v     = (last_step || !swap) ? head : nxt;
      mid       = count_ff >> 1;
      tail_idx  = IDX_W'(count_ff - CW'(1));
      pair_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
      final_rsp = (emit_ff == count_ff - CW'(1));

      state_in   = state_ff;
      sr_in      = sr_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      ovf_in     = ovf_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      step_in    = step_ff;
      moved_in   = moved_ff;
      emit_in    = emit_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      med_in     = med_ff;
      mean_in    = mean_ff;
      item_ready = 1'b0;
      div_start  = 1'b0;

      unique case (state_ff)
         // store requests until the end of the set
         ST_LOAD: begin
            item_ready = 1'b1;
            if (item_valid) begin
               if (!item.drop) begin
                  sr_in[IDX_W'(count_ff)] = item.value;
                  count_in = count_ff + CW'(1);
                  sum_in   = sum_ff + SUM_W'(item.value);
                  if (item.value < min_ff) begin
                     min_in = item.value;
                  end
                  if (item.value > max_ff) begin
                     max_in = item.value;
                  end
               end else begin
                  ovf_in = 1'b1;
               end
               if (item.last) begin
                  state_in = ST_SORT;
                  step_in  = CW'(1);
                  moved_in = 1'b0;
               end
            end
         end

         // one bubble step: head carries the larger, smaller goes to the tail
         ST_SORT: begin
            for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
               sr_in[i] = sr_ff[i + 1];
            end
            if (!last_step) begin
               sr_in[0] = swap ? head : nxt;
            end
            sr_in[tail_idx] = out_v;
            // keep the middle elements as they pass the tail
            if (step_ff == mid) begin
               lo_in = out_v;
            end
            if (step_ff == mid + CW'(1)) begin
               hi_in = out_v;
            end
            if (last_step) begin
               if (moved_ff) begin
                  step_in  = CW'(1);
                  moved_in = 1'b0;
               end else begin
                  state_in  = ST_MEAN;
                  div_start = 1'b1;
               end
            end else begin
               step_in  = step_ff + CW'(1);
               moved_in = moved_ff | swap;
            end
         end

         // wait for the mean, form the median
         ST_MEAN: begin
            med_in = count_ff[0] ? hi_ff : pair_sum[VW:1];
            if (div_done) begin
               mean_in  = sws_pkg::MEAN_W'(div_quo);
               state_in = ST_EMIT;
               emit_in  = '0;
            end
         end

         // shift out one response per accepted handshake
         ST_EMIT: begin
            if (rsp_tready) begin
               for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
                  sr_in[i] = sr_ff[i + 1];
               end
               if (final_rsp) begin
                  state_in = ST_LOAD;
                  count_in = '0;
                  sum_in   = '0;
                  ovf_in   = 1'b0;
                  min_in   = '1;
                  max_in   = '0;
               end else begin
                  emit_in = emit_ff + CW'(1);
               end
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         sum_ff   <= '0;
         ovf_ff   <= 1'b0;
         min_ff   <= '1;
         max_ff   <= '0;
         step_ff  <= '0;
         moved_ff <= 1'b0;
         emit_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         ovf_ff   <= ovf_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         step_ff  <= step_in;
         moved_ff <= moved_in;
         emit_ff  <= emit_in;
      end
      sr_ff   <= sr_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      med_ff  <= med_in;
      mean_ff <= mean_in;
   end

   // response fields straight from registers
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tlast  = final_rsp;
   assign rsp_tuser  = ovf_ff;
   assign rsp_tdata  = {sws_pkg::RSP_PAD_W'(0), mean_ff, med_ff, max_ff, min_ff,
                        sws_pkg::POS_W'(emit_ff), head};

endmodule

`default_nettype wire
